@@ rtl/icdo_pkg.sv @@
// Shared types, constants and helper functions for the integer calculator.
package icdo_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    function automatic int num_digits(int bits);
        longint unsigned v;
        int n;
        v = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
        n = 0;
        while (v != 0)
        begin
            n++;
            v = v / 10;
        end
        return n;
    endfunction

    localparam int ND = num_digits(WORD_BITS);
    localparam int DIG_W = $clog2(ND);
    localparam int BCD_W = 4 * ND;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;

    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_NL = 8'd10;

    localparam int STOP_IDX_W = 5;
    localparam int DIV_STOP_LEN = 23;
    localparam int MOD_STOP_LEN = 21;
    localparam logic [8*DIV_STOP_LEN-1:0] DIV_STOP_TEXT = "Stop : division by zero";
    localparam logic [8*MOD_STOP_LEN-1:0] MOD_STOP_TEXT = "Stop : modulo by zero";

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } arith_req_t;

    typedef struct packed {
        logic done;
        logic zero_div;
    } arith_stat_t;

    function automatic logic [7:0] stop_char(logic is_mod, logic [STOP_IDX_W-1:0] idx);
        int pos;
        logic [7:0] ch;
        if (is_mod)
        begin
            pos = MOD_STOP_LEN - 1 - int'(idx);
            ch = MOD_STOP_TEXT[8*pos +: 8];
        end
        else
        begin
            pos = DIV_STOP_LEN - 1 - int'(idx);
            ch = DIV_STOP_TEXT[8*pos +: 8];
        end
        return ch;
    endfunction

    function automatic word_t load_operand(logic [31:0] raw);
        logic signed [63:0] ext;
        ext = 64'(signed'(raw));
        return word_t'(ext);
    endfunction

endpackage

@@ rtl/icdo_in_if.sv @@
// Handshake channel that carries one calculation request word.
interface icdo_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b, input ready);
    modport sink (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

@@ rtl/icdo_out_if.sv @@
// Handshake channel that carries one output character word.
interface icdo_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink (input valid, input text_char, input is_last, output ready);
endinterface

@@ rtl/icdo_arith.sv @@
// Sequenced arithmetic unit built around one shared adder: add, subtract, multiply, divide, remainder.
module icdo_arith
    import icdo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  arith_req_t  req,
    input  word_t       a,
    input  word_t       b,
    output arith_stat_t stat,
    output word_t       mag,
    output logic        neg
);

    localparam logic [3:0] A_IDLE = 4'd0;
    localparam logic [3:0] A_ADD  = 4'd1;
    localparam logic [3:0] A_SUB  = 4'd2;
    localparam logic [3:0] A_MUL  = 4'd3;
    localparam logic [3:0] A_ABSA = 4'd4;
    localparam logic [3:0] A_ABSB = 4'd5;
    localparam logic [3:0] A_DIV  = 4'd6;
    localparam logic [3:0] A_FIX  = 4'd7;
    localparam logic [3:0] A_MAG  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            sh_reg, sh_next;
    word_t            opnd_reg, opnd_next;
    logic             na_reg, na_next;
    logic             nb_reg, nb_next;
    logic             is_rem_reg, is_rem_next;
    word_t            mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic             zdiv_reg, zdiv_next;

    logic [WORD_BITS:0] add_x, add_y, add_sum;
    logic               add_cin;
    word_t              shifted;
    word_t              fix_src;
    logic               fix_neg;
    logic               last_step;

    assign add_sum = add_x + add_y + (WORD_BITS + 1)'(add_cin);
    assign shifted = {acc_reg[WORD_BITS-2:0], sh_reg[WORD_BITS-1]};
    assign fix_src = is_rem_reg ? acc_reg : sh_reg;
    assign fix_neg = is_rem_reg ? na_reg : (na_reg ^ nb_reg);
    assign last_step = (cnt_reg == CNT_W'(WORD_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        sh_next = sh_reg;
        opnd_next = opnd_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        is_rem_next = is_rem_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        zdiv_next = zdiv_reg;
        done_next = 1'b0;
        add_x = '0;
        add_y = '0;
        add_cin = 1'b0;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    zdiv_next = 1'b0;
                    cnt_next = '0;
                    case (req.op)
                        OP_ADD:
                        begin
                            acc_next = a;
                            opnd_next = b;
                            state_next = A_ADD;
                        end
                        OP_SUB:
                        begin
                            acc_next = a;
                            opnd_next = b;
                            state_next = A_SUB;
                        end
                        OP_MUL:
                        begin
                            acc_next = '0;
                            opnd_next = a;
                            sh_next = b;
                            state_next = A_MUL;
                        end
                        OP_DIV, OP_REM:
                        begin
                            if (b == '0)
                            begin
                                zdiv_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = '0;
                                sh_next = a;
                                opnd_next = b;
                                na_next = a[WORD_BITS-1];
                                nb_next = b[WORD_BITS-1];
                                is_rem_next = (req.op == OP_REM);
                                state_next = A_ABSA;
                            end
                        end
                        default:
                        begin
                            acc_next = '0;
                            state_next = A_MAG;
                        end
                    endcase
                end
            end
            A_ADD:
            begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, opnd_reg};
                acc_next = add_sum[WORD_BITS-1:0];
                state_next = A_MAG;
            end
            A_SUB:
            begin
                add_x = {1'b0, acc_reg};
                add_y = ~{1'b0, opnd_reg};
                add_cin = 1'b1;
                acc_next = add_sum[WORD_BITS-1:0];
                state_next = A_MAG;
            end
            A_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = sh_reg[0] ? {1'b0, opnd_reg} : '0;
                acc_next = add_sum[WORD_BITS-1:0];
                opnd_next = {opnd_reg[WORD_BITS-2:0], 1'b0};
                sh_next = {1'b0, sh_reg[WORD_BITS-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = A_MAG;
                end
            end
            A_ABSA:
            begin
                add_y = ~{1'b0, sh_reg};
                add_cin = 1'b1;
                if (na_reg)
                begin
                    sh_next = add_sum[WORD_BITS-1:0];
                end
                state_next = A_ABSB;
            end
            A_ABSB:
            begin
                add_y = ~{1'b0, opnd_reg};
                add_cin = 1'b1;
                if (nb_reg)
                begin
                    opnd_next = add_sum[WORD_BITS-1:0];
                end
                state_next = A_DIV;
            end
            A_DIV:
            begin
                add_x = {1'b0, shifted};
                add_y = ~{1'b0, opnd_reg};
                add_cin = 1'b1;
                acc_next = add_sum[WORD_BITS] ? shifted : add_sum[WORD_BITS-1:0];
                sh_next = {sh_reg[WORD_BITS-2:0], ~add_sum[WORD_BITS]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                add_y = ~{1'b0, fix_src};
                add_cin = 1'b1;
                acc_next = fix_neg ? add_sum[WORD_BITS-1:0] : fix_src;
                state_next = A_MAG;
            end
            A_MAG:
            begin
                add_y = ~{1'b0, acc_reg};
                add_cin = 1'b1;
                neg_next = acc_reg[WORD_BITS-1];
                mag_next = acc_reg[WORD_BITS-1] ? add_sum[WORD_BITS-1:0] : acc_reg;
                done_next = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
            zdiv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
            zdiv_reg <= zdiv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg <= sh_next;
        opnd_reg <= opnd_next;
        na_reg <= na_next;
        nb_reg <= nb_next;
        is_rem_reg <= is_rem_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign stat.done = done_reg;
    assign stat.zero_div = zdiv_reg;
    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

@@ rtl/icdo_bcd.sv @@
// Binary to packed decimal converter that shifts in one bit per cycle.
module icdo_bcd
    import icdo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  word_t            value,
    output logic             done,
    output logic [BCD_W-1:0] digits
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                       : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            bin_next = value;
            bcd_next = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[WORD_BITS-1]};
            bin_next = {bin_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign digits = bcd_reg;

endmodule

@@ rtl/integer_calculator_decimal_out.sv @@
// Top level of the integer calculator that prints each result as decimal text.
// Arithmetic runs first; a result then goes through conversion to decimal, and the text leaves
// at one word per cycle while the receiver is ready, after up to ND-1 leading zero digits are
// skipped; a zero divisor goes straight to the text.
// One request is in flight at a time: a new word is taken once the newline is handed out.
// Reset is asynchronous and active low; it clears the sequencers and the output valid.
module integer_calculator_decimal_out
    import icdo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    icdo_in_if.sink           calc,
    icdo_out_if.source        chars
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_CONV  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;
    localparam logic [2:0] ST_STOP  = 3'd5;
    localparam logic [2:0] ST_NL    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic                  is_mod_reg, is_mod_next;
    logic                  neg_reg, neg_next;
    logic                  started_reg, started_next;
    logic [DIG_W-1:0]      didx_reg, didx_next;
    logic [STOP_IDX_W-1:0] sidx_reg, sidx_next;
    logic                  ov_reg, ov_next;
    logic [7:0]            ch_reg, ch_next;
    logic                  last_reg, last_next;

    arith_req_t       ar_req;
    arith_stat_t      ar_stat;
    word_t            ar_mag;
    logic             ar_neg;
    logic             bcd_start;
    logic             bcd_done;
    logic [BCD_W-1:0] bcd_digits;
    logic             accept;
    logic             slot_free;
    logic [3:0]       digit;
    logic             stop_end;

    assign calc.ready = (state_reg == ST_IDLE);
    assign accept = calc.valid && calc.ready;
    assign slot_free = !ov_reg || chars.ready;

    assign ar_req.start = accept;
    assign ar_req.op = calc.op;
    assign bcd_start = (state_reg == ST_CALC) && ar_stat.done && !ar_stat.zero_div;
    assign digit = bcd_digits[4*didx_reg +: 4];
    assign stop_end = is_mod_reg ? (sidx_reg == STOP_IDX_W'(MOD_STOP_LEN - 1))
                                 : (sidx_reg == STOP_IDX_W'(DIV_STOP_LEN - 1));

    icdo_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ar_req),
        .a     (load_operand(calc.operand_a)),
        .b     (load_operand(calc.operand_b)),
        .stat  (ar_stat),
        .mag   (ar_mag),
        .neg   (ar_neg)
    );

    icdo_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .value  (ar_mag),
        .done   (bcd_done),
        .digits (bcd_digits)
    );

    always_comb
    begin
        state_next = state_reg;
        is_mod_next = is_mod_reg;
        neg_next = neg_reg;
        started_next = started_reg;
        didx_next = didx_reg;
        sidx_next = sidx_reg;
        ov_next = ov_reg && !chars.ready;
        ch_next = ch_reg;
        last_next = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_mod_next = (calc.op == OP_REM);
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (ar_stat.done)
                begin
                    if (ar_stat.zero_div)
                    begin
                        sidx_next = '0;
                        state_next = ST_STOP;
                    end
                    else
                    begin
                        neg_next = ar_neg;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                begin
                    didx_next = DIG_W'(ND - 1);
                    started_next = 1'b0;
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ch_next = CH_MINUS;
                    last_next = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (!started_reg && (digit == 4'd0) && (didx_reg != '0))
                begin
                    didx_next = didx_reg - DIG_W'(1);
                end
                else if (slot_free)
                begin
                    ov_next = 1'b1;
                    ch_next = CH_ZERO + {4'd0, digit};
                    last_next = 1'b0;
                    started_next = 1'b1;
                    if (didx_reg == '0)
                    begin
                        state_next = ST_NL;
                    end
                    else
                    begin
                        didx_next = didx_reg - DIG_W'(1);
                    end
                end
            end
            ST_STOP:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ch_next = stop_char(is_mod_reg, sidx_reg);
                    last_next = 1'b0;
                    sidx_next = sidx_reg + STOP_IDX_W'(1);
                    if (stop_end)
                    begin
                        state_next = ST_NL;
                    end
                end
            end
            ST_NL:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ch_next = CH_NL;
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            started_reg <= 1'b0;
            didx_reg <= '0;
            sidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            started_reg <= started_next;
            didx_reg <= didx_next;
            sidx_reg <= sidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_mod_reg <= is_mod_next;
        neg_reg <= neg_next;
        ch_reg <= ch_next;
        last_reg <= last_next;
    end

    assign chars.valid = ov_reg;
    assign chars.text_char = ch_reg;
    assign chars.is_last = last_reg;

    a_arith_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        ar_stat.done |-> state_reg == ST_CALC)
        else $error("arithmetic result arrived outside the calculation phase");

    a_bcd_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_done |-> state_reg == ST_CONV)
        else $error("decimal conversion finished outside the conversion phase");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !calc.ready)
        else $error("request port ready right after taking a word");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NL) && slot_free |=> chars.valid && chars.is_last)
        else $error("newline not marked as the last word");

endmodule
